// ===== design/topic_subscription_matcher_assert.svh =====
// Assertion macros shared by the matcher modules.
// Expects signals named clk and rst in the module that uses them.
`ifndef TOPIC_SUBSCRIPTION_MATCHER_ASSERT_SVH
`define TOPIC_SUBSCRIPTION_MATCHER_ASSERT_SVH

// same-cycle implication
`define TSM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tsm assertion failed");

// next-cycle implication
`define TSM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tsm assertion failed");

`endif

// ===== design/tsm_pkg.sv =====
// Shared constants, codes and controller/datapath interface types
// for the topic subscription matcher. No dependencies.
package tsm_pkg;

  localparam int NUM_TOPICS_DEF      = 256;
  localparam int SLOTS_PER_TOPIC_DEF = 8;
  localparam int MAX_RESULTS         = 8;

  localparam logic [15:0] GROUP_MASK = 16'hFF00;

  localparam logic [1:0] OP_SUB   = 2'd0;
  localparam logic [1:0] OP_UNSUB = 2'd1;
  localparam logic [1:0] OP_PUB   = 2'd2;
  localparam logic [1:0] OP_NOP   = 2'd3;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_TOPIC = 3'd1;
  localparam logic [2:0] ST_DUPLICATE = 3'd2;
  localparam logic [2:0] ST_ROW_FULL  = 3'd3;
  localparam logic [2:0] ST_ABSENT    = 3'd4;

  typedef struct packed {
    logic latch;
    logic vread;
    logic quick_emit;
    logic rd;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic quick;
  } sts_t;

  typedef struct packed {
    logic [7:0]  requester;
    logic [7:0]  handler;
    logic [15:0] topic;
  } entry_t;

endpackage

// ===== design/tsm_ctrl.sv =====
// Sequencer for the matcher: accept, row check, slot scan, drain, finish.
// Depends on tsm_pkg and topic_subscription_matcher_assert.svh.
module tsm_ctrl #(
  parameter int SLOTS_PER_TOPIC = tsm_pkg::SLOTS_PER_TOPIC_DEF,
  localparam int SLOT_W = (SLOTS_PER_TOPIC > 1) ? $clog2(SLOTS_PER_TOPIC) : 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  tsm_pkg::sts_t     sts,
  output tsm_pkg::cmd_t     cmd,
  output logic [SLOT_W-1:0] scan_slot
);
  import tsm_pkg::*;
  `include "topic_subscription_matcher_assert.svh"

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CHECK  = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_DRAIN  = 3'd3;
  localparam logic [2:0] S_FINISH = 3'd4;

  logic [2:0]        state, state_next;
  logic [SLOT_W-1:0] slot, slot_next;

  always_comb begin
    state_next = state;
    slot_next  = slot;
    unique case (state)
      S_IDLE: begin
        if (start) state_next = S_CHECK;
      end
      S_CHECK: begin
        slot_next  = '0;
        state_next = sts.quick ? S_IDLE : S_SCAN;
      end
      S_SCAN: begin
        slot_next = slot + SLOT_W'(1);
        if (slot == SLOT_W'(SLOTS_PER_TOPIC - 1)) state_next = S_DRAIN;
      end
      S_DRAIN:  state_next = S_FINISH;
      S_FINISH: state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      slot  <= '0;
    end else begin
      state <= state_next;
      slot  <= slot_next;
    end
  end

  assign busy           = (state != S_IDLE);
  assign scan_slot      = slot;
  assign cmd.latch      = (state == S_IDLE) && start;
  assign cmd.vread      = (state == S_CHECK) && !sts.quick;
  assign cmd.quick_emit = (state == S_CHECK) && sts.quick;
  assign cmd.rd         = (state == S_SCAN);
  assign cmd.finish     = (state == S_FINISH);

  `TSM_ASSERT_NEXT(a_busy_after_accept, start && !busy, busy)
  `TSM_ASSERT_NEXT(a_finish_to_idle, cmd.finish, !busy)
  `TSM_ASSERT_NOW(a_scan_in_range, cmd.rd, scan_slot <= SLOT_W'(SLOTS_PER_TOPIC - 1))

endmodule

// ===== design/tsm_datapath.sv =====
// Slot table, valid rows, scan evaluation and result registers.
// Depends on tsm_pkg and topic_subscription_matcher_assert.svh.
module tsm_datapath #(
  parameter int NUM_TOPICS      = tsm_pkg::NUM_TOPICS_DEF,
  parameter int SLOTS_PER_TOPIC = tsm_pkg::SLOTS_PER_TOPIC_DEF,
  localparam int SLOT_W = (SLOTS_PER_TOPIC > 1) ? $clog2(SLOTS_PER_TOPIC) : 1
) (
  input  logic              clk,
  input  logic              rst,
  input  tsm_pkg::cmd_t     cmd,
  output tsm_pkg::sts_t     sts,
  input  logic [SLOT_W-1:0] scan_slot,
  input  logic [1:0]        opcode,
  input  logic [15:0]       topic,
  input  logic [7:0]        requester_id,
  input  logic [7:0]        handler_id,
  output logic              strobe,
  output logic [2:0]        status,
  output logic              matched,
  output logic [7:0]        match_handler,
  output logic [15:0]       match_topic,
  output logic              last
);
  import tsm_pkg::*;
  `include "topic_subscription_matcher_assert.svh"

  localparam int ROW_W  = (NUM_TOPICS > 1) ? $clog2(NUM_TOPICS) : 1;
  localparam int DEPTH  = NUM_TOPICS * SLOTS_PER_TOPIC;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(MAX_RESULTS + 1);

  // latched item
  logic [1:0]  op_q;
  logic [15:0] topic_q;
  logic [7:0]  req_q;
  logic [7:0]  hnd_q;

  logic [ROW_W-1:0] row;
  logic             bad_row;
  logic             all_groups;

  // valid rows: one flop per row marks the row as written since reset
  logic [NUM_TOPICS-1:0]      row_init;
  logic [SLOTS_PER_TOPIC-1:0] vmem [NUM_TOPICS];
  logic [SLOTS_PER_TOPIC-1:0] vrow_rd;
  logic                       rinit_q;
  logic [SLOTS_PER_TOPIC-1:0] vbits;
  logic [SLOTS_PER_TOPIC-1:0] vrow_new;

  entry_t dmem [DEPTH];
  entry_t rd_q;

  logic              eval_v;
  logic [SLOT_W-1:0] eval_slot;
  logic              entry_v;
  logic              pub_hit;

  logic              dup, free_v, hit_v, pend_v;
  logic [SLOT_W-1:0] free_idx, hit_idx;
  logic [7:0]        pend_hnd;
  logic [15:0]       pend_topic;
  logic [CNT_W-1:0]  n_cnt;

  logic              sub_ok, vwrite;

  logic        strobe_next, matched_next, last_next;
  logic [2:0]  status_next;
  logic [7:0]  handler_next;
  logic [15:0] mtopic_next;

  function automatic logic [ADDR_W-1:0] slot_addr(input logic [ROW_W-1:0] r,
                                                  input logic [SLOT_W-1:0] s);
    slot_addr = ADDR_W'(int'(r) * SLOTS_PER_TOPIC + int'(s));
  endfunction

  assign row        = topic_q[ROW_W-1:0];
  assign bad_row    = {1'b0, topic_q[7:0]} >= 9'(NUM_TOPICS);
  assign all_groups = (topic_q & GROUP_MASK) == 16'h0000;
  assign sts.quick  = (op_q == OP_NOP) || bad_row;

  assign vbits    = rinit_q ? vrow_rd : '0;
  assign entry_v  = eval_v && vbits[eval_slot];
  assign pub_hit  = entry_v && (op_q == OP_PUB) &&
                    (all_groups || rd_q.topic == topic_q) &&
                    (n_cnt != CNT_W'(MAX_RESULTS));
  assign sub_ok   = (op_q == OP_SUB) && !dup && free_v;
  assign vwrite   = cmd.finish && (sub_ok || ((op_q == OP_UNSUB) && hit_v));
  assign vrow_new = (op_q == OP_SUB) ? (vbits | (SLOTS_PER_TOPIC'(1) << free_idx))
                                     : (vbits & ~(SLOTS_PER_TOPIC'(1) << hit_idx));

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_q    <= opcode;
      topic_q <= topic;
      req_q   <= requester_id;
      hnd_q   <= handler_id;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_init <= '0;
    end else if (vwrite) begin
      row_init[row] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.vread) begin
      vrow_rd <= vmem[row];
      rinit_q <= row_init[row];
    end
    if (vwrite) vmem[row] <= vrow_new;
  end

  always_ff @(posedge clk) begin
    if (cmd.rd) rd_q <= dmem[slot_addr(row, scan_slot)];
    if (cmd.finish && sub_ok) dmem[slot_addr(row, free_idx)] <= '{req_q, hnd_q, topic_q};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      eval_v <= 1'b0;
    end else begin
      eval_v <= cmd.rd;
    end
    eval_slot <= scan_slot;
  end

  // scan flags
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      dup    <= 1'b0;
      free_v <= 1'b0;
      hit_v  <= 1'b0;
      pend_v <= 1'b0;
      n_cnt  <= '0;
    end else if (eval_v) begin
      if (entry_v && rd_q.requester == req_q) begin
        dup <= 1'b1;
        if (!hit_v) begin
          hit_v   <= 1'b1;
          hit_idx <= eval_slot;
        end
      end
      if (!vbits[eval_slot] && !free_v) begin
        free_v   <= 1'b1;
        free_idx <= eval_slot;
      end
      if (pub_hit) begin
        pend_v     <= 1'b1;
        pend_hnd   <= rd_q.handler;
        pend_topic <= rd_q.topic;
        n_cnt      <= n_cnt + CNT_W'(1);
      end
    end
  end

  // a match is held in the pending register so the final one can carry last
  always_comb begin
    strobe_next  = 1'b0;
    status_next  = ST_OK;
    matched_next = 1'b0;
    handler_next = '0;
    mtopic_next  = '0;
    last_next    = 1'b1;
    if (cmd.quick_emit) begin
      strobe_next = 1'b1;
      status_next = (op_q != OP_NOP && bad_row) ? ST_BAD_TOPIC : ST_OK;
    end else if (pub_hit && pend_v) begin
      strobe_next  = 1'b1;
      matched_next = 1'b1;
      handler_next = pend_hnd;
      mtopic_next  = pend_topic;
      last_next    = 1'b0;
    end else if (cmd.finish) begin
      strobe_next = 1'b1;
      case (op_q)
        OP_SUB: begin
          if (dup) status_next = ST_DUPLICATE;
          else if (!free_v) status_next = ST_ROW_FULL;
        end
        OP_UNSUB: begin
          if (!hit_v) status_next = ST_ABSENT;
        end
        default: begin
          if (pend_v) begin
            matched_next = 1'b1;
            handler_next = pend_hnd;
            mtopic_next  = pend_topic;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= strobe_next;
    end
    status        <= status_next;
    matched       <= matched_next;
    match_handler <= handler_next;
    match_topic   <= mtopic_next;
    last          <= last_next;
  end

  `TSM_ASSERT_NOW(a_unmatched_is_last, strobe && !matched, last)
  `TSM_ASSERT_NOW(a_match_status_ok, strobe && matched, status == ST_OK)
  `TSM_ASSERT_NEXT(a_gap_after_last, strobe && last, !strobe)

endmodule

// ===== design/topic_subscription_matcher.sv =====
// Top level of the topic subscription matcher.
// Instantiates tsm_ctrl and tsm_datapath; depends on tsm_pkg.
//
// An item is taken when start is high and busy is low. Opcode three and
// topics whose row is at or beyond NUM_TOPICS skip the scan; the check
// state gives their single result and returns the block to idle. Subscribe,
// unsubscribe and publish scan the row one slot a cycle through the
// single-port slot memory: busy stays high through the check, scan, drain
// and finish states, so a new item waits until the block is idle. A publish
// delivers up to eight results, each under strobe, the last marked
// by last; nothing holds results back, so the receiver must take each one in
// the cycle it is shown. Valid rows are tracked by a per-row flag cleared at
// reset, so the block is ready right after reset with no clearing pass.
module topic_subscription_matcher #(
  parameter int NUM_TOPICS      = tsm_pkg::NUM_TOPICS_DEF,
  parameter int SLOTS_PER_TOPIC = tsm_pkg::SLOTS_PER_TOPIC_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  opcode,
  input  logic [15:0] topic,
  input  logic [7:0]  requester_id,
  input  logic [7:0]  handler_id,
  output logic        strobe,
  output logic [2:0]  status,
  output logic        matched,
  output logic [7:0]  match_handler,
  output logic [15:0] match_topic,
  output logic        last
);
  import tsm_pkg::*;

  localparam int SLOT_W = (SLOTS_PER_TOPIC > 1) ? $clog2(SLOTS_PER_TOPIC) : 1;

  cmd_t              cmd;
  sts_t              sts;
  logic [SLOT_W-1:0] scan_slot;

  tsm_ctrl #(
    .SLOTS_PER_TOPIC(SLOTS_PER_TOPIC)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .sts      (sts),
    .cmd      (cmd),
    .scan_slot(scan_slot)
  );

  tsm_datapath #(
    .NUM_TOPICS     (NUM_TOPICS),
    .SLOTS_PER_TOPIC(SLOTS_PER_TOPIC)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .scan_slot    (scan_slot),
    .opcode       (opcode),
    .topic        (topic),
    .requester_id (requester_id),
    .handler_id   (handler_id),
    .strobe       (strobe),
    .status       (status),
    .matched      (matched),
    .match_handler(match_handler),
    .match_topic  (match_topic),
    .last         (last)
  );

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking bench for topic_subscription_matcher: directed and random
// subscribe/unsubscribe/publish traffic against a slot-table predictor.
// Depends on tsm_pkg and the matcher RTL.
module tb_top;
  import tsm_pkg::*;

  localparam int NUM_ROWS   = NUM_TOPICS_DEF;
  localparam int ROW_SLOTS  = SLOTS_PER_TOPIC_DEF;
  localparam int RAND_ITEMS = 460;
  localparam int CYCLE_CAP  = 200000;
  localparam int DRAIN      = 2 * (SLOTS_PER_TOPIC_DEF + 4);

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] topic;
    logic [7:0]  req;
    logic [7:0]  hnd;
  } request_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        matched;
    logic [7:0]  handler;
    logic [15:0] topic;
    logic        last;
  } notice_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic [1:0]  opcode = OP_SUB;
  logic [15:0] topic = 16'h0;
  logic [7:0]  requester_id = 8'h0;
  logic [7:0]  handler_id = 8'h0;
  logic        busy;
  logic        strobe;
  logic [2:0]  status;
  logic        matched;
  logic [7:0]  match_handler;
  logic [15:0] match_topic;
  logic        last;

  request_t pending_requests[$];
  notice_t  due_notices[$];

  logic        sub_live    [NUM_ROWS][ROW_SLOTS];
  logic [7:0]  sub_owner   [NUM_ROWS][ROW_SLOTS];
  logic [7:0]  sub_handler [NUM_ROWS][ROW_SLOTS];
  logic [15:0] sub_topic   [NUM_ROWS][ROW_SLOTS];

  logic took = 1'b0;
  int   gap_left = 0;
  int   calm_run = 0;
  int   cycles = 0;
  int   fails = 0;
  int   n_taken = 0;
  int   n_checked = 0;
  int   n_op [4];
  int   n_deliveries = 0;
  int   n_unmatched = 0;
  int   n_dup = 0;
  int   n_full = 0;
  int   n_absent = 0;
  int   n_bad = 0;

  topic_subscription_matcher uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .opcode(opcode), .topic(topic), .requester_id(requester_id),
    .handler_id(handler_id), .strobe(strobe), .status(status),
    .matched(matched), .match_handler(match_handler),
    .match_topic(match_topic), .last(last)
  );

  always #5 clk = ~clk;

  task automatic flag_mismatch(input string what);
    fails++;
    if (fails <= 50) $display("MISMATCH @%0d: %s", cycles, what);
  endtask

  task automatic queue_item(input logic [1:0] op, input logic [15:0] tp,
                            input logic [7:0] req, input logic [7:0] hnd);
    request_t r;
    r = '{op, tp, req, hnd};
    pending_requests.push_back(r);
  endtask

  task automatic push_single(input logic [2:0] st);
    notice_t n;
    n = '{st, 1'b0, 8'h0, 16'h0, 1'b1};
    due_notices.push_back(n);
  endtask

  // table update and expected results for one accepted transfer
  task automatic route_request(input logic [1:0] op, input logic [15:0] tp,
                               input logic [7:0] req, input logic [7:0] hnd);
    int row;
    int free_idx;
    int hits;
    int k;
    bit dup;
    bit everyone;
    notice_t n;
    row = int'(tp[7:0]);
    free_idx = -1;
    hits = 0;
    k = 0;
    dup = 1'b0;
    everyone = ((tp & GROUP_MASK) == 16'h0);
    n_op[op]++;
    if (op == OP_NOP) begin
      push_single(ST_OK);
    end else if (row >= NUM_ROWS) begin
      n_bad++;
      push_single(ST_BAD_TOPIC);
    end else begin
      case (op)
        OP_SUB: begin
          for (int i = 0; i < ROW_SLOTS; i++) begin
            if (!sub_live[row][i]) begin
              if (free_idx < 0) free_idx = i;
            end else if (sub_owner[row][i] == req) begin
              dup = 1'b1;
            end
          end
          if (dup) begin
            n_dup++;
            push_single(ST_DUPLICATE);
          end else if (free_idx < 0) begin
            n_full++;
            push_single(ST_ROW_FULL);
          end else begin
            sub_live[row][free_idx] = 1'b1;
            sub_owner[row][free_idx] = req;
            sub_handler[row][free_idx] = hnd;
            sub_topic[row][free_idx] = tp;
            push_single(ST_OK);
          end
        end
        OP_UNSUB: begin
          for (int i = 0; i < ROW_SLOTS; i++) begin
            if (free_idx < 0 && sub_live[row][i] && sub_owner[row][i] == req) begin
              free_idx = i;
            end
          end
          if (free_idx >= 0) begin
            sub_live[row][free_idx] = 1'b0;
            push_single(ST_OK);
          end else begin
            n_absent++;
            push_single(ST_ABSENT);
          end
        end
        default: begin
          for (int i = 0; i < ROW_SLOTS; i++) begin
            if (sub_live[row][i] && (everyone || sub_topic[row][i] == tp)) hits++;
          end
          if (hits > MAX_RESULTS) hits = MAX_RESULTS;
          if (hits == 0) begin
            n_unmatched++;
            push_single(ST_OK);
          end
          for (int i = 0; i < ROW_SLOTS; i++) begin
            if (k < hits && sub_live[row][i] &&
                (everyone || sub_topic[row][i] == tp)) begin
              n = '{ST_OK, 1'b1, sub_handler[row][i], sub_topic[row][i],
                    (k == hits - 1)};
              due_notices.push_back(n);
              n_deliveries++;
              k++;
            end
          end
        end
      endcase
    end
  endtask

  function automatic int next_gap();
    int r;
    if (calm_run > 0) begin
      calm_run--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) calm_run = $urandom_range(10, 30);
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(13, 40);
  endfunction

  // driver
  always @(negedge clk) begin
    request_t nxt;
    if (!rst && (!start || took)) begin
      if (gap_left > 0) begin
        start <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_requests.size() > 0) begin
        nxt = pending_requests.pop_front();
        opcode <= nxt.op;
        topic <= nxt.topic;
        requester_id <= nxt.req;
        handler_id <= nxt.hnd;
        start <= 1'b1;
        gap_left <= next_gap();
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: result check, then prediction for the transfer taken this edge
  always @(posedge clk) begin
    notice_t want;
    notice_t got;
    cycles <= cycles + 1;
    if (rst) begin
      took <= 1'b0;
    end else begin
      took <= start && !busy;
      if (strobe) begin
        got = '{status, matched, match_handler, match_topic, last};
        if (due_notices.size() == 0) begin
          flag_mismatch($sformatf("unexpected result %p", got));
        end else begin
          want = due_notices.pop_front();
          n_checked++;
          if (got.status !== want.status || got.matched !== want.matched ||
              got.handler !== want.handler || got.topic !== want.topic ||
              got.last !== want.last) begin
            flag_mismatch($sformatf("got %p want %p", got, want));
          end
        end
      end
      if (start && !busy) begin
        n_taken++;
        route_request(opcode, topic, requester_id, handler_id);
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > CYCLE_CAP) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycles, due_notices.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    logic [7:0] hot_rows [3];
    logic [7:0] groups [4];
    logic [7:0] pool [10];
    logic [7:0] row;
    logic [7:0] grp;
    logic [7:0] who;
    logic [1:0] op;
    int r;

    for (int i = 0; i < NUM_ROWS; i++)
      for (int j = 0; j < ROW_SLOTS; j++) sub_live[i][j] = 1'b0;
    for (int i = 0; i < 4; i++) n_op[i] = 0;

    // directed: fill row zero, overflow, duplicate, fan-out and removal
    queue_item(OP_PUB, 16'h0000, 8'h00, 8'h00);
    queue_item(OP_SUB, 16'h0000, 8'h00, 8'h00);
    queue_item(OP_SUB, 16'hFF00, 8'hFF, 8'hFF);
    for (int i = 1; i <= 6; i++)
      queue_item(OP_SUB, {8'(i * 8'h11), 8'h00}, 8'(i), 8'(8'h10 + i));
    queue_item(OP_SUB, 16'h4400, 8'h07, 8'h77);
    queue_item(OP_SUB, 16'h3300, 8'h03, 8'h99);
    queue_item(OP_PUB, 16'h0000, 8'h00, 8'h00);
    queue_item(OP_PUB, 16'hFF00, 8'h12, 8'hFF);
    queue_item(OP_PUB, 16'h7700, 8'h00, 8'h00);
    queue_item(OP_UNSUB, 16'hFF00, 8'hFF, 8'h00);
    queue_item(OP_UNSUB, 16'hFF00, 8'hFF, 8'h00);
    queue_item(OP_SUB, 16'hFF00, 8'h07, 8'hA5);
    queue_item(OP_PUB, 16'hFF00, 8'h00, 8'h00);
    queue_item(OP_NOP, 16'hFFFF, 8'hFF, 8'hFF);
    queue_item(OP_SUB, 16'hFFFF, 8'hAA, 8'h55);
    queue_item(OP_PUB, 16'hFFFF, 8'hFF, 8'hFF);
    queue_item(OP_PUB, 16'h00FF, 8'h00, 8'h00);
    queue_item(OP_UNSUB, 16'h00FF, 8'h55, 8'h00);

    // random: a few busy rows and a small requester pool so rows fill up
    for (int i = 0; i < 3; i++) hot_rows[i] = 8'($urandom);
    groups[0] = 8'h00;
    groups[1] = 8'h01 + 8'($urandom_range(0, 253));
    groups[2] = 8'h01 + 8'($urandom_range(0, 253));
    groups[3] = 8'hFF;
    for (int i = 0; i < 10; i++) pool[i] = 8'($urandom);
    for (int n = 0; n < RAND_ITEMS; n++) begin
      r = $urandom_range(0, 99);
      if (r < 40) op = OP_SUB;
      else if (r < 65) op = OP_UNSUB;
      else if (r < 95) op = OP_PUB;
      else op = OP_NOP;
      row = ($urandom_range(0, 99) < 85) ? hot_rows[$urandom_range(0, 2)]
                                         : 8'($urandom);
      grp = ($urandom_range(0, 9) == 0) ? 8'($urandom) : groups[$urandom_range(0, 3)];
      who = ($urandom_range(0, 99) < 85) ? pool[$urandom_range(0, 9)] : 8'($urandom);
      queue_item(op, {grp, row}, who, 8'($urandom));
    end

    repeat (11) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    while (!(pending_requests.size() == 0 && !start && due_notices.size() == 0))
      @(posedge clk);
    repeat (DRAIN) @(posedge clk);

    $display("%0d transfers (sub %0d, unsub %0d, pub %0d, idle op %0d), %0d results checked",
             n_taken, n_op[OP_SUB], n_op[OP_UNSUB], n_op[OP_PUB], n_op[OP_NOP], n_checked);
    $display("%0d deliveries, %0d empty publishes, dup %0d, full %0d, absent %0d, bad row %0d",
             n_deliveries, n_unmatched, n_dup, n_full, n_absent, n_bad);
    if (fails == 0 && due_notices.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
